### sv/hix_pkg.sv
package hix_pkg;

  localparam int MAX_ORDER = 16;

  localparam int ORDER_W = 5;
  localparam int CELL_W  = 16;
  localparam int IDX_W   = 32;
  localparam int POS_W   = 32;
  localparam int COORD_W = MAX_ORDER;
  localparam int CFG_W   = CELL_W;
  localparam int CFG_IDX_W = 1;

  // levels 1 .. MAX_ORDER-1, four per pipeline stage
  localparam int LVL_PER_STAGE  = 4;
  localparam int NUM_LVL_STAGES = (MAX_ORDER - 1 + LVL_PER_STAGE - 1) / LVL_PER_STAGE;
  localparam int STAGE_W        = (NUM_LVL_STAGES > 1) ? $clog2(NUM_LVL_STAGES) : 1;
  localparam int LVL_W          = $clog2(NUM_LVL_STAGES * LVL_PER_STAGE + 1);

  localparam logic [CFG_IDX_W-1:0] REG_CURVE_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 1'd1;

  localparam logic [1:0] OP_SWAP = 2'd0;
  localparam logic [1:0] OP_UP   = 2'd1;
  localparam logic [1:0] OP_DIAG = 2'd2;
  localparam logic [1:0] OP_FLIP = 2'd3;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd1;
  localparam logic [CELL_W-1:0]  CELL_RESET  = 16'd1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } coord_pair_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;   // index bits not yet consumed, next level in [1:0]
    coord_pair_t      pt;
  } pipe_t;

  function automatic logic [ORDER_W-1:0] clamp_order(logic [ORDER_W-1:0] o);
    logic [ORDER_W-1:0] r;
    r = o;
    if (o > ORDER_W'(MAX_ORDER)) r = ORDER_W'(MAX_ORDER);
    if (o == '0) r = ORDER_W'(1);
    return r;
  endfunction

  function automatic coord_pair_t base_point(logic [1:0] sel);
    coord_pair_t r;
    r = '0;
    case (sel)
      2'd0: begin r.x = COORD_W'(0); r.y = COORD_W'(0); end
      2'd1: begin r.x = COORD_W'(0); r.y = COORD_W'(1); end
      2'd2: begin r.x = COORD_W'(1); r.y = COORD_W'(1); end
      2'd3: begin r.x = COORD_W'(1); r.y = COORD_W'(0); end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Coordinates entering level lvl are below h, so adding h is setting bit lvl
  // and h-1-v is the low lvl bits of ~v.
  function automatic coord_pair_t apply_level(coord_pair_t p, logic [1:0] op,
                                              logic [LVL_W-1:0] lvl);
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] m;
    coord_pair_t        r;
    h = COORD_W'(1) << lvl;
    m = h - COORD_W'(1);
    r = p;
    case (op)
      OP_SWAP: begin r.x = p.y; r.y = p.x; end
      OP_UP:   begin r.y = p.y | h; end
      OP_DIAG: begin r.x = p.x | h; r.y = p.y | h; end
      OP_FLIP: begin r.x = (m & ~p.y) | h; r.y = m & ~p.x; end
      default: r = p;
    endcase
    return r;
  endfunction

endpackage

### sv/hix_if.sv
interface hix_idx_if;
  logic                         valid;
  logic                         ready;
  logic [hix_pkg::IDX_W-1:0]    hilbert_index;

  modport source (output valid, output hilbert_index, input ready);
  modport sink   (input valid, input hilbert_index, output ready);
endinterface

interface hix_pt_if;
  logic                         valid;
  logic                         ready;
  logic [hix_pkg::POS_W-1:0]    x_pos;
  logic [hix_pkg::POS_W-1:0]    y_pos;

  modport source (output valid, output x_pos, output y_pos, input ready);
  modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

### sv/hix_base_stage.sv
module hix_base_stage (
  input  logic           clk,
  input  logic           rst,
  hix_idx_if.sink        index_ch,
  output logic           dn_valid,
  input  logic           dn_ready,
  output hix_pkg::pipe_t dn_data
);

  logic           valid;
  hix_pkg::pipe_t data;

  assign index_ch.ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (index_ch.ready) begin
      valid <= index_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (index_ch.valid && index_ch.ready) begin
      data.pt  <= hix_pkg::base_point(index_ch.hilbert_index[1:0]);
      data.idx <= index_ch.hilbert_index >> 2;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

### sv/hix_level_stage.sv
module hix_level_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hix_pkg::STAGE_W-1:0]   stage_num,
  input  logic [hix_pkg::ORDER_W-1:0]   order_eff,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  hix_pkg::pipe_t                up_data,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output hix_pkg::pipe_t                dn_data
);

  logic           valid;
  hix_pkg::pipe_t data;
  hix_pkg::pipe_t data_next;

  always_comb begin
    logic [hix_pkg::LVL_W-1:0] lvl;
    data_next = up_data;
    for (int k = 0; k < hix_pkg::LVL_PER_STAGE; k++) begin
      lvl = hix_pkg::LVL_W'(stage_num) * hix_pkg::LVL_W'(hix_pkg::LVL_PER_STAGE)
            + hix_pkg::LVL_W'(k + 1);
      if (lvl < order_eff) begin
        data_next.pt = hix_pkg::apply_level(data_next.pt, data_next.idx[1:0], lvl);
      end
      data_next.idx = data_next.idx >> 2;
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

### sv/hix_scale_stage.sv
module hix_scale_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [hix_pkg::CELL_W-1:0]  cell_size,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  hix_pkg::pipe_t              up_data,
  hix_pt_if.source                    point_ch
);

  logic                       valid;
  logic [hix_pkg::POS_W-1:0]  x_pos;
  logic [hix_pkg::POS_W-1:0]  y_pos;

  assign up_ready = !valid || point_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  // 16x16 products, always fit in 32 bits
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      x_pos <= hix_pkg::POS_W'(up_data.pt.x) * hix_pkg::POS_W'(cell_size);
      y_pos <= hix_pkg::POS_W'(up_data.pt.y) * hix_pkg::POS_W'(cell_size);
    end
  end

  assign point_ch.valid = valid;
  assign point_ch.x_pos = x_pos;
  assign point_ch.y_pos = y_pos;

endmodule

### sv/hilbert_index_to_xy.sv
// Hilbert index to (x, y) times cell size, six register stages.
// Throughput: one item per cycle while results are taken; ready chains back through the stages,
// so empty stages fill while the output register holds a result.
// Reset (rst, synchronous): all stages empty, curve_order = 1, cell_size = 1.
module hilbert_index_to_xy (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hix_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hix_pkg::CFG_W-1:0]       cfg_data,
  hix_idx_if.sink                         index_ch,
  hix_pt_if.source                        point_ch
);

  logic [hix_pkg::ORDER_W-1:0] curve_order;
  logic [hix_pkg::CELL_W-1:0]  cell_size;
  logic [hix_pkg::ORDER_W-1:0] order_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order <= hix_pkg::ORDER_RESET;
      cell_size   <= hix_pkg::CELL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hix_pkg::REG_CURVE_ORDER: curve_order <= cfg_data[hix_pkg::ORDER_W-1:0];
        hix_pkg::REG_CELL_SIZE:   cell_size   <= cfg_data[hix_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  assign order_eff = hix_pkg::clamp_order(curve_order);

  logic           st_valid [hix_pkg::NUM_LVL_STAGES+1];
  logic           st_ready [hix_pkg::NUM_LVL_STAGES+1];
  hix_pkg::pipe_t st_data  [hix_pkg::NUM_LVL_STAGES+1];

  hix_base_stage u_base (
    .clk      (clk),
    .rst      (rst),
    .index_ch (index_ch),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_data  (st_data[0])
  );

  for (genvar s = 0; s < hix_pkg::NUM_LVL_STAGES; s++) begin : g_lvl
    hix_level_stage u_lvl (
      .clk       (clk),
      .rst       (rst),
      .stage_num (hix_pkg::STAGE_W'(s)),
      .order_eff (order_eff),
      .up_valid  (st_valid[s]),
      .up_ready  (st_ready[s]),
      .up_data   (st_data[s]),
      .dn_valid  (st_valid[s+1]),
      .dn_ready  (st_ready[s+1]),
      .dn_data   (st_data[s+1])
    );
  end

  hix_scale_stage u_scale (
    .clk       (clk),
    .rst       (rst),
    .cell_size (cell_size),
    .up_valid  (st_valid[hix_pkg::NUM_LVL_STAGES]),
    .up_ready  (st_ready[hix_pkg::NUM_LVL_STAGES]),
    .up_data   (st_data[hix_pkg::NUM_LVL_STAGES]),
    .point_ch  (point_ch)
  );

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !point_ch.valid)
    else $error("result valid right after reset");

  // with the output register empty every stage can move, so input is open
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !point_ch.valid |-> index_ch.ready)
    else $error("input stalled while output register empty");

  // after all levels the grid point lies inside the 2^order square
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    st_valid[hix_pkg::NUM_LVL_STAGES] |->
      ((st_data[hix_pkg::NUM_LVL_STAGES].pt.x >> order_eff) == '0) &&
      ((st_data[hix_pkg::NUM_LVL_STAGES].pt.y >> order_eff) == '0))
    else $error("grid point outside curve square");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [hix_pkg::POS_W-1:0] x_pos;
    logic [hix_pkg::POS_W-1:0] y_pos;
  } point_t;

  typedef struct packed {
    logic [hix_pkg::CFG_W-1:0] ord_data;
    logic [hix_pkg::CFG_W-1:0] cell_sz;
    logic [hix_pkg::IDX_W-1:0] idx;
    logic                      typed;
    logic [hix_pkg::POS_W-1:0] ex;
    logic [hix_pkg::POS_W-1:0] ey;
  } dir_row_t;

  localparam int N_DIR = 24;
  localparam int RAND_ITEMS = 1750;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;

  // order data, cell size, index, typed, x, y
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // reset values: order 1, cell 1
    '{16'h0001, 16'd1, 32'h0000_0000, 1'b1, 32'd0, 32'd0},
    '{16'h0001, 16'd1, 32'h0000_0001, 1'b1, 32'd0, 32'd1},
    '{16'h0001, 16'd1, 32'h0000_0002, 1'b1, 32'd1, 32'd1},
    '{16'h0001, 16'd1, 32'h0000_0003, 1'b1, 32'd1, 32'd0},
    '{16'h0001, 16'd1, 32'hFFFF_FFFC, 1'b1, 32'd0, 32'd0},
    '{16'h0001, 16'd1, 32'hFFFF_FFFF, 1'b1, 32'd1, 32'd0},
    // order zero acts as order 1
    '{16'h0000, 16'd1, 32'hFFFF_FFFE, 1'b1, 32'd1, 32'd1},
    // one level: each of the four ops
    '{16'h0002, 16'd1, 32'h0000_0004, 1'b1, 32'd0, 32'd2},
    '{16'h0002, 16'd1, 32'h0000_0000, 1'b1, 32'd0, 32'd0},
    '{16'h0002, 16'd1, 32'h0000_0001, 1'b1, 32'd1, 32'd0},
    '{16'h0002, 16'd1, 32'h0000_000B, 1'b1, 32'd3, 32'd2},
    '{16'h0002, 16'd1, 32'h0000_000C, 1'b1, 32'd3, 32'd1},
    '{16'h0002, 16'd1, 32'h0000_000F, 1'b1, 32'd3, 32'd0},
    // full order, max cell; upper data bits of the order write are dropped
    '{16'hFFF0, 16'hFFFF, 32'hAAAA_AAAA, 1'b1, 32'hFFFE_0001, 32'hFFFE_0001},
    '{16'hFFF0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0},
    '{16'hFFF0, 16'hFFFF, 32'h0000_0000, 1'b1, 32'd0, 32'd0},
    '{16'hFFF0, 16'hFFFF, 32'h5555_5555, 1'b0, 32'd0, 32'd0},
    // order 31 saturates to the max order
    '{16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA, 1'b1, 32'hFFFE_0001, 32'hFFFE_0001},
    '{16'hFFFF, 16'hFFFF, 32'h1234_5678, 1'b0, 32'd0, 32'd0},
    // zero cell, then nonzero cells at orders 1 and 5
    '{16'h0011, 16'h0000, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'd0},
    '{16'h0001, 16'hFFFF, 32'h0000_0002, 1'b1, 32'h0000_FFFF, 32'h0000_FFFF},
    '{16'h0001, 16'hFFFF, 32'h0000_0001, 1'b1, 32'd0, 32'h0000_FFFF},
    '{16'h7FE5, 16'h5A5A, 32'h3C3C_3C3C, 1'b0, 32'd0, 32'd0},
    '{16'h7FE5, 16'h5A5A, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [hix_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hix_pkg::CFG_W-1:0] cfg_data;

  hix_idx_if index_ch();
  hix_pt_if  point_ch();

  hilbert_index_to_xy uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .index_ch  (index_ch),
    .point_ch  (point_ch)
  );

  point_t pending_points[$];
  int mismatch_count = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  logic [hix_pkg::ORDER_W-1:0] cur_order;
  logic [hix_pkg::CELL_W-1:0] cur_cell;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("hilbert_index_to_xy test failed");
    $finish;
  end

  function automatic point_t hilbert_point(logic [hix_pkg::IDX_W-1:0] idx,
                                           logic [hix_pkg::ORDER_W-1:0] order,
                                           logic [hix_pkg::CELL_W-1:0] cell_sz);
    int unsigned levels;
    int unsigned lvl;
    logic [hix_pkg::IDX_W-1:0] rest;
    logic [63:0] x, y, t, h;
    point_t p;
    levels = order;
    if (levels > hix_pkg::MAX_ORDER) levels = hix_pkg::MAX_ORDER;
    if (levels == 0) levels = 1;
    case (idx[1:0])
      2'd0: begin x = 64'd0; y = 64'd0; end
      2'd1: begin x = 64'd0; y = 64'd1; end
      2'd2: begin x = 64'd1; y = 64'd1; end
      default: begin x = 64'd1; y = 64'd0; end
    endcase
    rest = idx >> 2;
    for (lvl = 1; lvl < levels; lvl++) begin
      h = 64'd1 << lvl;
      case (rest[1:0])
        hix_pkg::OP_SWAP: begin t = x; x = y; y = t; end
        hix_pkg::OP_UP: begin y = y + h; end
        hix_pkg::OP_DIAG: begin x = x + h; y = y + h; end
        default: begin
          t = y;
          y = (h - 64'd1) - x;
          x = (h - 64'd1) - t + h;
        end
      endcase
      rest = rest >> 2;
    end
    p.x_pos = hix_pkg::POS_W'(x * 64'(cell_sz));
    p.y_pos = hix_pkg::POS_W'(y * 64'(cell_sz));
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // called in the step of a rising edge; returns in the step of the accepting edge
  task automatic offer_index(input logic [hix_pkg::IDX_W-1:0] idx, input point_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        index_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    index_ch.valid <= 1'b1;
    index_ch.hilbert_index <= idx;
    do @(posedge clk); while (!index_ch.ready);
    pending_points.insert(pending_points.size(), want);
  endtask

  task automatic wait_points_drained();
    index_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_curve_cfg(input logic [hix_pkg::CFG_W-1:0] ord_data,
                                 input logic [hix_pkg::CFG_W-1:0] cell_sz);
    cfg_we <= 1'b1;
    cfg_index <= hix_pkg::REG_CURVE_ORDER;
    cfg_data <= ord_data;
    @(posedge clk);
    cfg_index <= hix_pkg::REG_CELL_SIZE;
    cfg_data <= cell_sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_data <= hix_pkg::CFG_W'($urandom);
    @(posedge clk);
    cur_order = ord_data[hix_pkg::ORDER_W-1:0];
    cur_cell = cell_sz;
  endtask

  // receiver: segments of random stall modes, plus one long hold-off on request
  initial begin
    int seg_left;
    int mode;
    int hold_left;
    int cyc;
    bit hold_done;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    cyc = 0;
    hold_done = 1'b0;
    point_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        point_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 200);
        end
        seg_left--;
        case (mode)
          0: point_ch.ready <= 1'b1;
          1: point_ch.ready <= 1'($urandom_range(0, 1));
          2: point_ch.ready <= ($urandom_range(0, 3) == 0);
          default: point_ch.ready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && point_ch.valid && point_ch.ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected point x=%0d y=%0d",
                                  point_ch.x_pos, point_ch.y_pos));
      end else begin
        want = pending_points.pop_front();
        if (point_ch.x_pos !== want.x_pos)
          report_mismatch($sformatf("x_pos got %0d want %0d", point_ch.x_pos, want.x_pos));
        if (point_ch.y_pos !== want.y_pos)
          report_mismatch($sformatf("y_pos got %0d want %0d", point_ch.y_pos, want.y_pos));
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int n_items;
    int k;
    logic [hix_pkg::CFG_W-1:0] ord_data;
    logic [hix_pkg::CFG_W-1:0] cell_sz;
    logic [hix_pkg::IDX_W-1:0] idx;
    point_t want;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    index_ch.valid <= 1'b0;
    index_ch.hilbert_index <= '0;
    cur_order = hix_pkg::ORDER_RESET;
    cur_cell = hix_pkg::CELL_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].ord_data[hix_pkg::ORDER_W-1:0] != cur_order ||
          DIR_ROWS[i].cell_sz != cur_cell) begin
        wait_points_drained();
        write_curve_cfg(DIR_ROWS[i].ord_data, DIR_ROWS[i].cell_sz);
      end
      if (DIR_ROWS[i].typed) begin
        want.x_pos = DIR_ROWS[i].ex;
        want.y_pos = DIR_ROWS[i].ey;
      end else begin
        want = hilbert_point(DIR_ROWS[i].idx, cur_order, cur_cell);
      end
      offer_index(DIR_ROWS[i].idx, want);
    end

    sent = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      wait_points_drained();
      k = $urandom_range(0, 9);
      ord_data = hix_pkg::CFG_W'($urandom);
      if (k == 0) begin
        ord_data[hix_pkg::ORDER_W-1:0] = '0;
      end else if (k == 1) begin
        ord_data[hix_pkg::ORDER_W-1:0] =
          hix_pkg::ORDER_W'($urandom_range(hix_pkg::MAX_ORDER + 1, 31));
      end else if (k == 2) begin
        ord_data[hix_pkg::ORDER_W-1:0] = hix_pkg::ORDER_W'(hix_pkg::MAX_ORDER);
      end else begin
        ord_data[hix_pkg::ORDER_W-1:0] =
          hix_pkg::ORDER_W'($urandom_range(1, hix_pkg::MAX_ORDER));
      end
      case ($urandom_range(0, 5))
        0: cell_sz = '0;
        1: cell_sz = '1;
        2: cell_sz = hix_pkg::CELL_W'(1);
        default: cell_sz = hix_pkg::CELL_W'($urandom_range(0, 65535));
      endcase
      write_curve_cfg(ord_data, cell_sz);
      if (phase == 2) hold_req = 1'b1;
      n_items = $urandom_range(40, 160);
      for (int j = 0; j < n_items; j++) begin
        idx = $urandom;
        // some indices with the bits above the order cleared
        if ($urandom_range(0, 4) == 0 && cur_order < hix_pkg::MAX_ORDER && cur_order != 0)
          idx = idx & ((hix_pkg::IDX_W'(1) << (2 * cur_order)) - hix_pkg::IDX_W'(1));
        offer_index(idx, hilbert_point(idx, cur_order, cur_cell));
      end
      sent += n_items;
      phase++;
    end

    wait_points_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hilbert_index_to_xy test passed");
    end else begin
      $display("hilbert_index_to_xy test failed");
    end
    $finish;
  end

endmodule
